@@ rtl/ipv4pc_pkg.sv @@
// shared types and constants for the ipv4 packet classifier
package ipv4pc_pkg;

  localparam int unsigned MaxPacketBytes = 65536;
  localparam int unsigned DefCountWidth  = 32;

  localparam logic [15:0] LenCap = (MaxPacketBytes > 65535) ? 16'hFFFF
                                                            : 16'(MaxPacketBytes);

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [15:0] MinIpBytes   = 16'd20;
  localparam logic [6:0]  TcpHdrBytes  = 7'd20;
  localparam logic [6:0]  UdpHdrBytes  = 7'd8;
  localparam logic [6:0]  IcmpHdrBytes = 7'd8;

  localparam logic [15:0] FlagOffset   = 16'd13;
  localparam logic [15:0] ScanBytes    = 16'd14;

  typedef enum logic [2:0] {
    ClsRunt  = 3'd0,
    ClsTcp   = 3'd1,
    ClsUdp   = 3'd2,
    ClsIcmp  = 3'd3,
    ClsOther = 3'd4
  } pkt_class_e;

  // capture state after the current beat
  typedef struct packed {
    logic [3:0]  hdr_words;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] tp_word0;
    logic [15:0] tp_word1;
    logic [7:0]  tcp_flags;
    logic [15:0] pkt_len;
  } hdr_fields_t;

endpackage

@@ rtl/ipv4pc_hdr_capture.sv @@
// per-byte header and transport field capture
module ipv4pc_hdr_capture
  import ipv4pc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output hdr_fields_t fields_o
);

  logic [15:0] idx_q, idx_d;
  logic [3:0]  hw_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] tp0_q, tp1_q;
  logic [7:0]  flag_q;

  hdr_fields_t f_d;
  logic [15:0] tp_off;
  logic [15:0] k;
  logic        in_tp;

  always_comb begin
    f_d.hdr_words = (idx_q == 16'd0) ? data_byte_i[3:0] : hw_q;
    tp_off        = {10'd0, f_d.hdr_words, 2'b00};
    f_d.proto     = (idx_q == 16'd9) ? data_byte_i : proto_q;
    f_d.src_addr  = (idx_q >= 16'd12 && idx_q < 16'd16) ? {src_q[23:0], data_byte_i} : src_q;
    f_d.dst_addr  = (idx_q >= 16'd16 && idx_q < 16'd20) ? {dst_q[23:0], data_byte_i} : dst_q;
    k             = idx_q - tp_off;
    in_tp         = (idx_q >= tp_off) && (k < ScanBytes);
    f_d.tp_word0  = tp0_q;
    f_d.tp_word1  = tp1_q;
    f_d.tcp_flags = flag_q;
    if (in_tp) begin
      if (k < 16'd2) begin
        f_d.tp_word0 = {tp0_q[7:0], data_byte_i};
      end else if (k < 16'd4) begin
        f_d.tp_word1 = {tp1_q[7:0], data_byte_i};
      end else if (k == FlagOffset) begin
        f_d.tcp_flags = data_byte_i;
      end
    end
    f_d.pkt_len = (idx_q < LenCap) ? idx_q + 16'd1 : LenCap;
    idx_d       = last_byte_i ? 16'd0 : f_d.pkt_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hw_q    <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      tp0_q   <= '0;
      tp1_q   <= '0;
      flag_q  <= '0;
    end else if (beat_i) begin
      idx_q   <= idx_d;
      hw_q    <= f_d.hdr_words;
      proto_q <= f_d.proto;
      src_q   <= f_d.src_addr;
      dst_q   <= f_d.dst_addr;
      tp0_q   <= f_d.tp_word0;
      tp1_q   <= f_d.tp_word1;
      flag_q  <= f_d.tcp_flags;
    end
  end

  assign fields_o = f_d;

endmodule

@@ rtl/ipv4_packet_classifier_unit.sv @@
// top level of the ipv4 packet classifier
// Usage: packet bytes enter on the input channel one beat per byte, starting
// at the first byte of the IPv4 header; last_byte_i marks the final beat of
// a packet. Each marked beat yields exactly one result beat on the output
// channel carrying the class, captured header fields, transport ports or icmp
// type/code, tcp flags, length and the updated counters; other beats yield
// nothing. A beat is held in an input register, and the result of a final
// beat is written from there to the output register, where it stays until
// the receiver takes it. One beat is taken every cycle while the output
// side keeps up; the limit is the single output register.
// When the receiver stalls, non-final bytes keep flowing and only a final
// byte waiting behind a held result stalls the input. Reset clears the byte
// position, all captured fields, the total and per-class counters and both
// valid flags. Counters are COUNT_WIDTH bits wide and wrap; runts (under 20
// bytes) are reported but not counted.
module ipv4_packet_classifier_unit
  import ipv4pc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  packet_class_o,
  output logic [7:0]  protocol_number_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] first_transport_word_o,
  output logic [15:0] second_transport_word_o,
  output logic [4:0]  tcp_flag_bits_o,
  output logic        transport_valid_o,
  output logic [15:0] packet_length_o,
  output logic [31:0] total_count_o,
  output logic [31:0] class_count_o
);

  localparam int unsigned NumCounters = 5;

  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_last_q;
  logic       s0_adv;
  logic       in_take;
  logic       out_valid_q;
  logic       res_load;

  hdr_fields_t fields;

  logic [COUNT_WIDTH-1:0] cnt_q [NumCounters];

  pkt_class_e cls;
  logic       is_runt;
  logic [6:0] tp_off;
  logic [6:0] need;
  logic       tp_ok;
  logic [15:0] w0, w1;
  logic [4:0]  flags;
  logic [COUNT_WIDTH-1:0] tot_next, cls_next;
  logic [COUNT_WIDTH+31:0] tot_ext, cls_ext;

  assign s0_adv     = s0_valid_q && !(s0_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s0_valid_q && !s0_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign res_load   = s0_adv && s0_last_q;

  ipv4pc_hdr_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (s0_adv),
    .data_byte_i (s0_byte_q),
    .last_byte_i (s0_last_q),
    .fields_o    (fields)
  );

  always_comb begin
    is_runt = fields.pkt_len < MinIpBytes;
    tp_off  = {1'b0, fields.hdr_words, 2'b00};
    priority if (fields.proto == ProtoTcp) begin
      cls  = ClsTcp;
      need = tp_off + TcpHdrBytes;
    end else if (fields.proto == ProtoUdp) begin
      cls  = ClsUdp;
      need = tp_off + UdpHdrBytes;
    end else if (fields.proto == ProtoIcmp) begin
      cls  = ClsIcmp;
      need = tp_off + IcmpHdrBytes;
    end else begin
      cls  = ClsOther;
      need = '0;
    end
    tp_ok = (cls != ClsOther) && (fields.pkt_len >= {9'd0, need});
    w0    = tp_ok ? fields.tp_word0 : 16'd0;
    w1    = (tp_ok && cls != ClsIcmp) ? fields.tp_word1 : 16'd0;
    flags = (tp_ok && cls == ClsTcp)
          ? {fields.tcp_flags[3], fields.tcp_flags[2], fields.tcp_flags[0],
             fields.tcp_flags[4], fields.tcp_flags[1]}
          : 5'd0;
    tot_next = cnt_q[ClsRunt] + COUNT_WIDTH'(1);
    cls_next = cnt_q[cls] + COUNT_WIDTH'(1);
    tot_ext  = {32'd0, is_runt ? cnt_q[ClsRunt] : tot_next};
    cls_ext  = {32'd0, cls_next};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_take) begin
      s0_valid_q <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_byte_q <= data_byte_i;
      s0_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // counter 0 holds the total, the others one class each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (res_load && !is_runt) begin
      cnt_q[ClsRunt] <= tot_next;
      cnt_q[cls]     <= cls_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      packet_length_o <= fields.pkt_len;
      total_count_o   <= tot_ext[31:0];
      if (is_runt) begin
        packet_class_o          <= ClsRunt;
        protocol_number_o       <= '0;
        source_address_o        <= '0;
        dest_address_o          <= '0;
        first_transport_word_o  <= '0;
        second_transport_word_o <= '0;
        tcp_flag_bits_o         <= '0;
        transport_valid_o       <= 1'b0;
        class_count_o           <= '0;
      end else begin
        packet_class_o          <= cls;
        protocol_number_o       <= fields.proto;
        source_address_o        <= fields.src_addr;
        dest_address_o          <= fields.dst_addr;
        first_transport_word_o  <= w0;
        second_transport_word_o <= w1;
        tcp_flag_bits_o         <= flags;
        transport_valid_o       <= tp_ok;
        class_count_o           <= cls_ext[31:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
